[sv/pts_pkg.sv]
// Package: types and constants of the priority thread scheduler.
package pts_pkg;
   localparam int THREAD_SLOTS = 8;
   localparam int EVENT_SLOTS  = 8;
   localparam int IDENT_BITS   = 16;
   localparam int SLOT_BITS    = $clog2(THREAD_SLOTS);
   localparam int EVT_BITS     = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
   localparam int CNT_BITS     = $clog2(THREAD_SLOTS + 1);
   localparam int ECNT_BITS    = $clog2(EVENT_SLOTS + 1);
   localparam int WALK_BITS    = $clog2(2 * THREAD_SLOTS + 1);

   typedef enum logic [2:0] {
      FUNC_TICK     = 3'd0,
      FUNC_SCHEDULE = 3'd1,
      FUNC_ADD      = 3'd2,
      FUNC_KILL_ID  = 3'd3,
      FUNC_KILL_SELF= 3'd4,
      FUNC_SLEEP    = 3'd5,
      FUNC_ADD_EVT  = 3'd6,
      FUNC_NONE     = 3'd7
   } func_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_THREAD_FULL= 2'd1,
      ST_EVENT_FULL = 2'd2,
      ST_LAST_THREAD= 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_WAKE,
      S_EVENT,
      S_EVT_OUT,
      S_WALK,
      S_KILL,
      S_RESP
   } state_type;
endpackage

[sv/priority_thread_scheduler_top.sv]
// Top level: priority thread scheduler with sleep and periodic events.
// Takes one command word at a time over req_valid/req_ready and answers with one
// or more result words on rsp_valid/rsp_ready (last marks the final one). A small
// sequencer steps a single shared slot unit over the tables. A tick wakes due
// sleepers slot by slot, then checks the event slots in turn and sends one result
// word per fired event (the result side may stall it), then closes with a final
// word. Schedule and kill by id walk the ring node by node; kill stops at the first
// match. Other commands go from accept straight to the result state. The next
// command is taken once the final result word has left the output register.
module priority_thread_scheduler_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [2:0]                      req_func,
   input  logic [7:0]                      req_priority_req,
   input  logic [15:0]                     req_thread_id,
   input  logic [31:0]                     req_sleep_ticks,
   input  logic [31:0]                     req_period,
   input  logic [31:0]                     req_first_delay,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_status,
   output logic                            rsp_event_fired,
   output logic [2:0]                      rsp_event_index,
   output logic                            rsp_switch_request,
   output logic                            rsp_running_valid,
   output logic [2:0]                      rsp_running_slot,
   output logic [15:0]                     rsp_running_id,
   output logic [3:0]                      rsp_thread_count,
   output logic [2:0]                      rsp_assigned_slot,
   output logic [15:0]                     rsp_assigned_id,
   output logic                            rsp_last
);
   import pts_pkg::*;

   // slot tables
   logic [THREAD_SLOTS-1:0]  alive_ff, asleep_ff;
   logic [7:0]               prio_ff  [THREAD_SLOTS];
   logic [31:0]              wake_ff  [THREAD_SLOTS];
   logic [SLOT_BITS-1:0]     next_ff  [THREAD_SLOTS];
   logic [SLOT_BITS-1:0]     prev_ff  [THREAD_SLOTS];
   logic [IDENT_BITS-1:0]    ident_ff [THREAD_SLOTS];
   logic [31:0]              eper_ff  [EVENT_SLOTS];
   logic [31:0]              edue_ff  [EVENT_SLOTS];

   logic [31:0]              time_ff;
   logic [SLOT_BITS-1:0]     cur_ff;
   logic                     curv_ff;
   logic [CNT_BITS-1:0]      live_ff;
   logic [IDENT_BITS-1:0]    idc_ff;
   logic [ECNT_BITS-1:0]     ecnt_ff;

   state_type                state_ff;
   func_type                 func_ff;
   logic [15:0]              tid_ff;
   logic [WALK_BITS-1:0]     step_ff;
   logic [SLOT_BITS-1:0]     node_ff;
   logic [8:0]               best_ff;
   logic [SLOT_BITS-1:0]     pick_ff;
   logic                     found_ff;
   logic [ECNT_BITS-1:0]     eidx_ff;

   // output register
   logic                     ovalid_ff;
   logic [1:0]               ostat_ff;
   logic                     ofired_ff, osw_ff, olast_ff;
   logic [2:0]               oeidx_ff, oaslot_ff;
   logic [15:0]              oaid_ff;

   logic accept;
   assign req_ready = (state_ff == S_IDLE) && !ovalid_ff;
   assign accept    = req_valid && req_ready;

   // lowest live and lowest free slot
   logic [SLOT_BITS-1:0] low_alive, low_free;
   logic                 any_free;
   always_comb begin
      low_alive = '0;
      low_free  = '0;
      any_free  = 1'b0;
      for (int s = THREAD_SLOTS - 1; s >= 0; s--) begin
         if (alive_ff[s]) low_alive = SLOT_BITS'(s);
         if (!alive_ff[s]) begin
            low_free = SLOT_BITS'(s);
            any_free = 1'b1;
         end
      end
   end

   logic [SLOT_BITS-1:0] walk_start;
   assign walk_start = curv_ff ? next_ff[cur_ff] : low_alive;

   logic [31:0] due_next;
   logic        evt_hit;
   logic [31:0] sum_in;
   // event adder: time + event period
   always_comb begin
      case (state_ff)
         S_EVENT: sum_in = eper_ff[eidx_ff[EVT_BITS-1:0]];
         default: sum_in = 32'd0;
      endcase
   end
   assign due_next = time_ff + sum_in;
   assign evt_hit  = time_ff >= edue_ff[eidx_ff[EVT_BITS-1:0]];

   logic node_ok;
   assign node_ok = alive_ff[node_ff] && !asleep_ff[node_ff] &&
                    ({1'b0, prio_ff[node_ff]} < best_ff);

   logic rsp_fire;
   assign rsp_fire = ovalid_ff && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         alive_ff  <= '0;
         asleep_ff <= '0;
         time_ff   <= '0;
         cur_ff    <= '0;
         curv_ff   <= 1'b1;
         live_ff   <= '0;
         idc_ff    <= '0;
         ecnt_ff   <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         if (rsp_fire) ovalid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  func_ff  <= func_type'(req_func);
                  tid_ff   <= req_thread_id;
                  step_ff  <= '0;
                  node_ff  <= walk_start;
                  best_ff  <= 9'd256;
                  found_ff <= 1'b0;
                  eidx_ff  <= '0;
                  ostat_ff <= ST_OK; ofired_ff <= 1'b0; oeidx_ff <= '0;
                  osw_ff <= 1'b0; oaslot_ff <= '0; oaid_ff <= '0; olast_ff <= 1'b1;
                  state_ff <= S_RESP;
                  case (func_type'(req_func))
                     FUNC_TICK: begin
                        time_ff  <= time_ff + 32'd1;
                        node_ff  <= '0;
                        state_ff <= S_WAKE;
                     end
                     FUNC_SCHEDULE: state_ff <= S_WALK;
                     FUNC_ADD: begin
                        if (live_ff >= CNT_BITS'(THREAD_SLOTS) || !any_free) begin
                           ostat_ff <= ST_THREAD_FULL;
                        end else begin
                           if (live_ff == '0) begin
                              next_ff[low_free] <= low_free;
                              prev_ff[low_free] <= low_free;
                           end else if (curv_ff && alive_ff[cur_ff]) begin
                              prev_ff[low_free] <= cur_ff;
                              next_ff[low_free] <= next_ff[cur_ff];
                              prev_ff[next_ff[cur_ff]] <= low_free;
                              next_ff[cur_ff] <= low_free;
                           end else begin
                              prev_ff[low_free] <= low_alive;
                              next_ff[low_free] <= next_ff[low_alive];
                              prev_ff[next_ff[low_alive]] <= low_free;
                              next_ff[low_alive] <= low_free;
                           end
                           prio_ff[low_free]  <= req_priority_req;
                           asleep_ff[low_free] <= 1'b0;
                           alive_ff[low_free] <= 1'b1;
                           ident_ff[low_free] <= idc_ff;
                           idc_ff    <= idc_ff + IDENT_BITS'(1);
                           live_ff   <= live_ff + CNT_BITS'(1);
                           oaslot_ff <= 3'(low_free);
                           oaid_ff   <= 16'(idc_ff);
                        end
                     end
                     FUNC_KILL_ID: begin
                        if (live_ff <= CNT_BITS'(1)) ostat_ff <= ST_LAST_THREAD;
                        else state_ff <= S_KILL;
                     end
                     FUNC_KILL_SELF: begin
                        if (live_ff <= CNT_BITS'(1)) ostat_ff <= ST_LAST_THREAD;
                        else if (curv_ff && alive_ff[cur_ff]) begin
                           next_ff[prev_ff[cur_ff]] <= next_ff[cur_ff];
                           prev_ff[next_ff[cur_ff]] <= prev_ff[cur_ff];
                           alive_ff[cur_ff]  <= 1'b0;
                           asleep_ff[cur_ff] <= 1'b0;
                           live_ff <= live_ff - CNT_BITS'(1);
                           osw_ff  <= 1'b1;
                        end
                     end
                     FUNC_SLEEP: begin
                        if (curv_ff) begin
                           wake_ff[cur_ff]   <= time_ff + req_sleep_ticks;
                           asleep_ff[cur_ff] <= 1'b1;
                           osw_ff <= 1'b1;
                        end
                     end
                     FUNC_ADD_EVT: begin
                        if (ecnt_ff >= ECNT_BITS'(EVENT_SLOTS)) ostat_ff <= ST_EVENT_FULL;
                        else begin
                           eper_ff[ecnt_ff[EVT_BITS-1:0]] <= req_period;
                           edue_ff[ecnt_ff[EVT_BITS-1:0]] <= time_ff + req_first_delay;
                           oaslot_ff <= 3'(ecnt_ff);
                           ecnt_ff   <= ecnt_ff + ECNT_BITS'(1);
                        end
                     end
                     default: ;
                  endcase
               end
            end
            S_WAKE: begin
               // one slot per cycle
               if (alive_ff[node_ff] && asleep_ff[node_ff] && wake_ff[node_ff] <= time_ff)
                  asleep_ff[node_ff] <= 1'b0;
               node_ff <= node_ff + SLOT_BITS'(1);
               if (node_ff == SLOT_BITS'(THREAD_SLOTS - 1)) state_ff <= S_EVENT;
            end
            S_EVENT: begin
               if (eidx_ff >= ecnt_ff) begin
                  osw_ff <= 1'b1; olast_ff <= 1'b1;
                  state_ff <= S_RESP;
               end else if (evt_hit) begin
                  edue_ff[eidx_ff[EVT_BITS-1:0]] <= due_next;
                  ofired_ff <= 1'b1; olast_ff <= 1'b0;
                  oeidx_ff  <= 3'(eidx_ff);
                  state_ff  <= S_EVT_OUT;
               end else begin
                  eidx_ff <= eidx_ff + ECNT_BITS'(1);
               end
            end
            S_EVT_OUT: begin
               if (!ovalid_ff) begin
                  ovalid_ff <= 1'b1;
                  state_ff  <= S_EVT_OUT;
               end
               if (rsp_fire) begin
                  ofired_ff <= 1'b0; oeidx_ff <= '0;
                  eidx_ff  <= eidx_ff + ECNT_BITS'(1);
                  state_ff <= S_EVENT;
               end
            end
            S_WALK: begin
               if (node_ok) begin
                  best_ff <= {1'b0, prio_ff[node_ff]};
                  pick_ff <= node_ff;
                  found_ff <= 1'b1;
               end
               node_ff <= next_ff[node_ff];
               step_ff <= step_ff + WALK_BITS'(1);
               if (step_ff == WALK_BITS'(2 * THREAD_SLOTS - 1)) state_ff <= S_RESP;
            end
            S_KILL: begin
               if (alive_ff[node_ff] && ident_ff[node_ff] == IDENT_BITS'(tid_ff)) begin
                  next_ff[prev_ff[node_ff]] <= next_ff[node_ff];
                  prev_ff[next_ff[node_ff]] <= prev_ff[node_ff];
                  alive_ff[node_ff]  <= 1'b0;
                  asleep_ff[node_ff] <= 1'b0;
                  live_ff  <= live_ff - CNT_BITS'(1);
                  state_ff <= S_RESP;
               end else begin
                  node_ff <= next_ff[node_ff];
                  step_ff <= step_ff + WALK_BITS'(1);
                  if (step_ff == WALK_BITS'(2 * THREAD_SLOTS - 1)) state_ff <= S_RESP;
               end
            end
            S_RESP: begin
               // schedule commits its pick here
               if (func_ff == FUNC_SCHEDULE) begin
                  curv_ff <= found_ff;
                  if (found_ff) cur_ff <= pick_ff;
               end
               ovalid_ff <= 1'b1;
               state_ff  <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid          = ovalid_ff && (state_ff == S_IDLE || state_ff == S_EVT_OUT);
   assign rsp_status         = ostat_ff;
   assign rsp_event_fired    = ofired_ff;
   assign rsp_event_index    = oeidx_ff;
   assign rsp_switch_request = osw_ff;
   assign rsp_running_valid  = curv_ff;
   assign rsp_running_slot   = 3'(cur_ff);
   assign rsp_running_id     = curv_ff ? 16'(ident_ff[cur_ff]) : 16'd0;
   assign rsp_thread_count   = 4'(live_ff);
   assign rsp_assigned_slot  = oaslot_ff;
   assign rsp_assigned_id    = oaid_ff;
   assign rsp_last           = olast_ff;

   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid)
      else $error("command taken while result pending");
   assert property (@(posedge clock) disable iff (reset)
      live_ff <= CNT_BITS'(THREAD_SLOTS))
      else $error("live count overflow");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_fired) |-> !rsp_last)
      else $error("event word marked last");
endmodule

[dv/tb_priority_thread_scheduler_top.sv]
// Testbench: priority thread scheduler driven with directed and random command words.
`timescale 1ns / 1ps

module tb_priority_thread_scheduler_top;
   import pts_pkg::*;

   localparam int RANDOM_WORDS = 290;
   localparam int QUIET_WORDS  = 40;
   localparam int CYCLE_LIMIT  = 400000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_func;
   logic [7:0]  req_priority_req;
   logic [15:0] req_thread_id;
   logic [31:0] req_sleep_ticks;
   logic [31:0] req_period;
   logic [31:0] req_first_delay;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_status;
   logic        rsp_event_fired;
   logic [2:0]  rsp_event_index;
   logic        rsp_switch_request;
   logic        rsp_running_valid;
   logic [2:0]  rsp_running_slot;
   logic [15:0] rsp_running_id;
   logic [3:0]  rsp_thread_count;
   logic [2:0]  rsp_assigned_slot;
   logic [15:0] rsp_assigned_id;
   logic        rsp_last;

   priority_thread_scheduler_top dut (.*);

   // One command word as sent, plus an optional status typed in by hand.
   typedef struct {
      func_type    func;
      bit [7:0]    prio;
      bit [15:0]   tid;
      bit [31:0]   sticks;
      bit [31:0]   per;
      bit [31:0]   dly;
      bit          pinned;
      status_type  pin_status;
   } command_type;

   // One result word as the scheduler should answer it.
   typedef struct {
      status_type  status;
      bit          fired;
      bit [2:0]    eidx;
      bit          sw;
      bit          run_ok;
      bit [2:0]    run_slot;
      bit [15:0]   run_id;
      bit [3:0]    count;
      bit [2:0]    aslot;
      bit [15:0]   aid;
      bit          last;
   } sched_word_type;

   sched_word_type pending_words[$];
   int          mismatches = 0;
   int          cycles = 0;
   bit          quiet = 0;
   int          stall_left = 0;

   // Shadow copy of the scheduler tables.
   bit [31:0] now_ticks;
   bit        alive [8];
   bit        asleep [8];
   bit [7:0]  prio_of [8];
   bit [31:0] wake_at [8];
   bit [2:0]  nxt [8];
   bit [2:0]  prv [8];
   bit [15:0] ident [8];
   bit [2:0]  cur;
   bit        cur_ok;
   int        live;
   bit [15:0] id_ctr;
   int        n_evt;
   bit [31:0] evt_per [8];
   bit [31:0] evt_due [8];

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // Give up on a hung scheduler.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic report(input string what, input longint expv, input longint gotv);
      $display("MISMATCH %s: expected %0h got %0h at %0t", what, expv, gotv, $realtime);
      mismatches++;
   endtask

   function automatic void push_word(status_type st, bit fired, bit [2:0] eidx, bit sw,
                                     bit [2:0] aslot, bit [15:0] aid, bit last);
      sched_word_type w;
      w.status   = st;
      w.fired    = fired;
      w.eidx     = eidx;
      w.sw       = sw;
      w.run_ok   = cur_ok;
      w.run_slot = cur;
      w.run_id   = cur_ok ? ident[cur] : 16'd0;
      w.count    = live[3:0];
      w.aslot    = aslot;
      w.aid      = aid;
      w.last     = last;
      pending_words.push_back(w);
   endfunction

   function automatic int lowest_live();
      for (int s = 0; s < 8; s++)
         if (alive[s]) return s;
      return -1;
   endfunction

   function automatic int lowest_free();
      for (int s = 0; s < 8; s++)
         if (!alive[s]) return s;
      return -1;
   endfunction

   function automatic bit [2:0] ring_start();
      int s;
      if (cur_ok) return nxt[cur];
      s = lowest_live();
      return (s < 0) ? 3'd0 : 3'(s);
   endfunction

   function automatic void drop_slot(bit [2:0] s);
      nxt[prv[s]] = nxt[s];
      prv[nxt[s]] = prv[s];
      alive[s]  = 0;
      asleep[s] = 0;
      if (live > 0) live--;
   endfunction

   function automatic void scheduler_reset();
      now_ticks = 0;
      foreach (alive[s]) begin
         alive[s]  = 0;
         asleep[s] = 0;
      end
      cur    = 0;
      cur_ok = 1;
      live   = 0;
      id_ctr = 0;
      n_evt  = 0;
   endfunction

   // Work out the result words a command causes and advance the shadow tables.
   function automatic void predict_schedule(command_type c);
      bit [2:0]  node;
      bit [2:0]  pick;
      bit [8:0]  best;
      bit        found;
      int        free_s;
      bit [2:0]  a;
      case (c.func)
         FUNC_TICK: begin
            now_ticks = now_ticks + 32'd1;
            for (int s = 0; s < 8; s++)
               if (alive[s] && asleep[s] && wake_at[s] <= now_ticks) asleep[s] = 0;
            for (int i = 0; i < n_evt; i++)
               if (now_ticks >= evt_due[i]) begin
                  evt_due[i] = now_ticks + evt_per[i];
                  push_word(ST_OK, 1, 3'(i), 0, 0, 0, 0);
               end
            push_word(ST_OK, 0, 0, 1, 0, 0, 1);
         end
         FUNC_SCHEDULE: begin
            best  = 9'd256;
            pick  = 0;
            found = 0;
            node  = ring_start();
            for (int i = 0; i < 16; i++) begin
               if (alive[node] && !asleep[node] && {1'b0, prio_of[node]} < best) begin
                  best  = {1'b0, prio_of[node]};
                  pick  = node;
                  found = 1;
               end
               node = nxt[node];
            end
            cur_ok = found;
            if (found) cur = pick;
            push_word(ST_OK, 0, 0, 0, 0, 0, 1);
         end
         FUNC_ADD: begin
            free_s = lowest_free();
            if (live >= 8 || free_s < 0) begin
               push_word(ST_THREAD_FULL, 0, 0, 0, 0, 0, 1);
            end else begin
               if (live == 0) begin
                  nxt[free_s] = 3'(free_s);
                  prv[free_s] = 3'(free_s);
               end else begin
                  a = (cur_ok && alive[cur]) ? cur : 3'(lowest_live());
                  prv[free_s] = a;
                  nxt[free_s] = nxt[a];
                  prv[nxt[a]] = 3'(free_s);
                  nxt[a] = 3'(free_s);
               end
               prio_of[free_s] = c.prio;
               asleep[free_s]  = 0;
               alive[free_s]   = 1;
               ident[free_s]   = id_ctr;
               id_ctr = id_ctr + 16'd1;
               live++;
               push_word(ST_OK, 0, 0, 0, 3'(free_s), ident[free_s], 1);
            end
         end
         FUNC_KILL_ID: begin
            if (live <= 1) begin
               push_word(ST_LAST_THREAD, 0, 0, 0, 0, 0, 1);
            end else begin
               node = ring_start();
               for (int i = 0; i < 16; i++) begin
                  if (alive[node] && ident[node] == c.tid) begin
                     drop_slot(node);
                     break;
                  end
                  node = nxt[node];
               end
               push_word(ST_OK, 0, 0, 0, 0, 0, 1);
            end
         end
         FUNC_KILL_SELF: begin
            if (live <= 1) begin
               push_word(ST_LAST_THREAD, 0, 0, 0, 0, 0, 1);
            end else if (cur_ok && alive[cur]) begin
               drop_slot(cur);
               push_word(ST_OK, 0, 0, 1, 0, 0, 1);
            end else begin
               push_word(ST_OK, 0, 0, 0, 0, 0, 1);
            end
         end
         FUNC_SLEEP: begin
            if (cur_ok) begin
               wake_at[cur] = now_ticks + c.sticks;
               asleep[cur]  = 1;
               push_word(ST_OK, 0, 0, 1, 0, 0, 1);
            end else begin
               push_word(ST_OK, 0, 0, 0, 0, 0, 1);
            end
         end
         FUNC_ADD_EVT: begin
            if (n_evt >= 8) begin
               push_word(ST_EVENT_FULL, 0, 0, 0, 0, 0, 1);
            end else begin
               evt_per[n_evt] = c.per;
               evt_due[n_evt] = now_ticks + c.dly;
               n_evt++;
               push_word(ST_OK, 0, 0, 0, 3'(n_evt - 1), 0, 1);
            end
         end
         default: push_word(ST_OK, 0, 0, 0, 0, 0, 1);
      endcase
   endfunction

   // Compare every result word leaving the scheduler with the oldest expectation.
   always @(posedge clock) begin
      sched_word_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_words.size() == 0) begin
            report("unexpected word", 0, rsp_status);
         end else begin
            w = pending_words.pop_front();
            if (rsp_status != w.status) report("status", w.status, rsp_status);
            if (rsp_event_fired != w.fired) report("event_fired", w.fired, rsp_event_fired);
            if (rsp_event_index != w.eidx) report("event_index", w.eidx, rsp_event_index);
            if (rsp_switch_request != w.sw) report("switch_request", w.sw, rsp_switch_request);
            if (rsp_running_valid != w.run_ok)
               report("running_valid", w.run_ok, rsp_running_valid);
            if (rsp_running_slot != w.run_slot)
               report("running_slot", w.run_slot, rsp_running_slot);
            if (rsp_running_id != w.run_id) report("running_id", w.run_id, rsp_running_id);
            if (rsp_thread_count != w.count) report("thread_count", w.count, rsp_thread_count);
            if (rsp_assigned_slot != w.aslot)
               report("assigned_slot", w.aslot, rsp_assigned_slot);
            if (rsp_assigned_id != w.aid) report("assigned_id", w.aid, rsp_assigned_id);
            if (rsp_last != w.last) report("last", w.last, rsp_last);
         end
      end
   end

   // Result side: stall in bursts; no new burst starts during the quiet tail.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 14);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Present one command word, hold it until taken, then predict its results.
   task automatic send_word(command_type c);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= c.func;
      req_priority_req <= c.prio;
      req_thread_id    <= c.tid;
      req_sleep_ticks  <= c.sticks;
      req_period       <= c.per;
      req_first_delay  <= c.dly;
      do @(posedge clock); while (!req_ready);
      predict_schedule(c);
      if (c.pinned) pending_words[$].status = c.pin_status;
   endtask

   function automatic bit [31:0] pick_ticks();
      return ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 6);
   endfunction

   function automatic command_type random_word(bit grow);
      command_type c;
      int roll;
      c.pinned = 0;
      c.pin_status = ST_OK;
      c.prio   = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
      c.tid    = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                             : id_ctr - 16'($urandom_range(1, 10));
      c.sticks = pick_ticks();
      c.per    = pick_ticks();
      c.dly    = pick_ticks();
      roll = $urandom_range(0, 99);
      if (grow && roll < 50)  c.func = FUNC_ADD;
      else if (roll < 30)     c.func = FUNC_TICK;
      else if (roll < 50)     c.func = FUNC_SCHEDULE;
      else if (roll < 62)     c.func = FUNC_ADD;
      else if (roll < 72)     c.func = FUNC_KILL_ID;
      else if (roll < 79)     c.func = FUNC_KILL_SELF;
      else if (roll < 89)     c.func = FUNC_SLEEP;
      else if (roll < 97)     c.func = FUNC_ADD_EVT;
      else                    c.func = FUNC_NONE;
      return c;
   endfunction

   command_type directed [] = '{
      // first word must add a thread: slot 0, id 0
      '{FUNC_ADD,       8'hFF, 16'h0000, 32'd0, 32'd0, 32'd0, 1'b1, ST_OK},
      '{FUNC_KILL_SELF, 8'h00, 16'h0000, 32'd0, 32'd0, 32'd0, 1'b1, ST_LAST_THREAD},
      '{FUNC_KILL_ID,   8'h00, 16'h0000, 32'd0, 32'd0, 32'd0, 1'b1, ST_LAST_THREAD},
      '{FUNC_ADD,       8'h00, 16'h0000, 32'd0, 32'd0, 32'd0, 1'b1, ST_OK},
      '{FUNC_SCHEDULE,  8'h00, 16'h0000, 32'd0, 32'd0, 32'd0, 1'b0, ST_OK},
      '{FUNC_TICK,      8'h00, 16'h0000, 32'd0, 32'd0, 32'd0, 1'b0, ST_OK},
      '{FUNC_ADD_EVT,   8'h00, 16'h0000, 32'd0, 32'd0, 32'd0, 1'b1, ST_OK},
      '{FUNC_ADD_EVT,   8'h00, 16'h0000, 32'd0, '1, '1, 1'b1, ST_OK},
      '{FUNC_TICK,      8'h00, 16'h0000, 32'd0, 32'd0, 32'd0, 1'b0, ST_OK},
      '{FUNC_SLEEP,     8'h00, 16'h0000, 32'd0, 32'd0, 32'd0, 1'b0, ST_OK},
      '{FUNC_SCHEDULE,  8'h00, 16'h0000, 32'd0, 32'd0, 32'd0, 1'b0, ST_OK},
      '{FUNC_SLEEP,     8'h00, 16'h0000, '1, 32'd0, 32'd0, 1'b0, ST_OK},
      // nobody ready: running_valid drops
      '{FUNC_SCHEDULE,  8'h00, 16'h0000, 32'd0, 32'd0, 32'd0, 1'b0, ST_OK},
      '{FUNC_SLEEP,     8'h00, 16'h0000, 32'd5, 32'd0, 32'd0, 1'b0, ST_OK},
      '{FUNC_SCHEDULE,  8'h00, 16'h0000, 32'd0, 32'd0, 32'd0, 1'b0, ST_OK},
      '{FUNC_SLEEP,     8'h00, 16'h0000, 32'd0, 32'd0, 32'd0, 1'b0, ST_OK},
      '{FUNC_KILL_SELF, 8'h00, 16'h0000, 32'd0, 32'd0, 32'd0, 1'b1, ST_OK},
      '{FUNC_ADD,       8'h80, 16'h0000, 32'd0, 32'd0, 32'd0, 1'b1, ST_OK},
      '{FUNC_KILL_ID,   8'h00, 16'hFFFF, 32'd0, 32'd0, 32'd0, 1'b1, ST_OK},
      '{FUNC_KILL_ID,   8'h00, 16'h0001, 32'd0, 32'd0, 32'd0, 1'b1, ST_OK},
      '{FUNC_TICK,      8'h00, 16'h0000, 32'd0, 32'd0, 32'd0, 1'b0, ST_OK},
      '{FUNC_NONE,      8'hFF, 16'hFFFF, '1, '1, '1, 1'b1, ST_OK},
      '{FUNC_SCHEDULE,  8'h00, 16'h0000, 32'd0, 32'd0, 32'd0, 1'b0, ST_OK}
   };

   initial begin
      command_type c;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_func         <= FUNC_TICK;
      req_priority_req <= '0;
      req_thread_id    <= '0;
      req_sleep_ticks  <= '0;
      req_period       <= '0;
      req_first_delay  <= '0;
      scheduler_reset();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send_word(directed[i]);

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         // halfway: hold off until every word in flight has come back
         if (n == RANDOM_WORDS / 2) begin
            req_valid <= 1'b0;
            while (pending_words.size() != 0) @(posedge clock);
         end
         quiet = (n >= RANDOM_WORDS - QUIET_WORDS);
         c = random_word(n >= 60 && n < 90);
         send_word(c);
      end
      req_valid <= 1'b0;

      while (pending_words.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule

[priority_thread_scheduler_top.f]
sv/pts_pkg.sv
sv/priority_thread_scheduler_top.sv
dv/tb_priority_thread_scheduler_top.sv
